// ===== design/sparse_triplet_merge_add_top_assert.svh =====
// assertion macros for the sparse triplet merge block
`ifndef SPARSE_TRIPLET_MERGE_ADD_TOP_ASSERT_SVH
`define SPARSE_TRIPLET_MERGE_ADD_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define STMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/stma_pkg.sv =====
// types and constants shared by the sparse triplet merge block
package stma_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SUM_W    = VAL_W + 1;
  localparam int unsigned KEY_W    = ROW_W + COL_W;
  localparam int unsigned ENTRY_W  = KEY_W + VAL_W;
  localparam int unsigned ORIGIN_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef enum logic [ORIGIN_W-1:0] {
    ORIG_A  = 2'd0,
    ORIG_B  = 2'd1,
    ORIG_AB = 2'd2
  } origin_t;

  // controller to datapath
  typedef struct packed {
    logic    wr_a;
    logic    wr_b;
    logic    set_ovf;
    logic    clr;
    logic    ptr_rst;
    logic    fetch;
    logic    emit;
    origin_t origin;
    logic    last;
  } stma_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_full;
    logic b_full;
    logic both_empty;
    logic a_left;
    logic b_left;
    logic a_more;
    logic b_more;
    logic a_lt;
    logic a_gt;
    logic out_busy;
  } stma_sts_t;

endpackage

// ===== design/stma_if.sv =====
// valid/ready channel interfaces for the triplet input and the merged results
interface stma_in_if import stma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [ROW_W-1:0]        row_index;
  logic [COL_W-1:0]        col_index;
  logic signed [VAL_W-1:0] entry_value;

  modport source(output valid, op, row_index, col_index, entry_value, input ready);
  modport sink(input valid, op, row_index, col_index, entry_value, output ready);
endinterface

interface stma_out_if import stma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [SUM_W-1:0] out_value;
  logic [ORIGIN_W-1:0]     origin_code;
  logic                    last_entry;
  logic                    overflow_seen;

  modport source(output valid, out_row, out_col, out_value, origin_code, last_entry,
                 overflow_seen, input ready);
  modport sink(input valid, out_row, out_col, out_value, origin_code, last_entry,
               overflow_seen, output ready);
endinterface

// ===== design/sparse_triplet_merge_add_top.sv =====
// sparse triplet merge-add: load transfers are accepted back to back
// run: accepted in idle, then per result a registered list read (fetch), then compare/add (emit)
// the first result shows after the fetch and emit states; a stalled consumer holds the merge
// a run over empty lists gives no result and returns at once
// rst_n (synchronous) clears counts, overflow flag, controller and result valid
// list contents are not cleared; entries past the counts are never used
module sparse_triplet_merge_add_top import stma_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input logic         clk,
  input logic         rst_n,
  stma_in_if.sink     in_if,
  stma_out_if.source  out_if
);

  stma_cmd_t cmd;
  stma_sts_t sts;
  logic      in_ready;

  assign in_if.ready = in_ready;

  stma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_if.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  stma_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .row_index     (in_if.row_index),
    .col_index     (in_if.col_index),
    .entry_value   (in_if.entry_value),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_row       (out_if.out_row),
    .out_col       (out_if.out_col),
    .out_value     (out_if.out_value),
    .origin_code   (out_if.origin_code),
    .last_entry    (out_if.last_entry),
    .overflow_seen (out_if.overflow_seen)
  );

endmodule

// ===== design/stma_ctrl.sv =====
// controller: accepts loads and runs, sequences the two-pointer merge
module stma_ctrl import stma_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  stma_sts_t       sts,
  output stma_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   take_a, take_b;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // merge decision on the keys currently at the read registers
  assign take_a = !sts.b_left || (sts.a_left && sts.a_lt);
  assign take_b = !take_a && (!sts.a_left || sts.a_gt);

  always_comb begin
    cmd       = '0;
    cmd.origin = ORIG_A;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_op == OP_LOAD_A) begin
            cmd.wr_a    = !sts.a_full;
            cmd.set_ovf = sts.a_full;
          end else if (in_op == OP_LOAD_B) begin
            cmd.wr_b    = !sts.b_full;
            cmd.set_ovf = sts.b_full;
          end else if (in_op == OP_RUN) begin
            if (sts.both_empty) begin
              cmd.clr = 1'b1;
            end else begin
              cmd.ptr_rst = 1'b1;
              state_nxt   = ST_FETCH;
            end
          end else begin
            cmd.clr = 1'b0;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        priority if (take_a) begin
          cmd.origin = ORIG_A;
          cmd.last   = !sts.a_more && !sts.b_left;
        end else if (take_b) begin
          cmd.origin = ORIG_B;
          cmd.last   = !sts.a_left && !sts.b_more;
        end else begin
          cmd.origin = ORIG_AB;
          cmd.last   = !sts.a_more && !sts.b_more;
        end
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          cmd.clr   = cmd.last;
          state_nxt = cmd.last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/stma_dp.sv =====
// datapath: list memories, counts, merge pointers, key compare, adder, result register
module stma_dp import stma_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stma_cmd_t               cmd,
  output stma_sts_t               sts,
  input  logic [ROW_W-1:0]        row_index,
  input  logic [COL_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] entry_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ROW_W-1:0]        out_row,
  output logic [COL_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] out_value,
  output logic [ORIGIN_W-1:0]     origin_code,
  output logic                    last_entry,
  output logic                    overflow_seen
);

  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

  logic [ENTRY_W-1:0] mem_a [LIST_DEPTH];
  logic [ENTRY_W-1:0] mem_b [LIST_DEPTH];

  logic [ENTRY_W-1:0] rd_a_r, rd_b_r;
  logic [CNT_W-1:0]   cnt_a_r, cnt_b_r;
  logic [CNT_W-1:0]   ptr_a_r, ptr_b_r;
  logic               ovf_r;

  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic [COL_W-1:0]        out_col_r;
  logic signed [SUM_W-1:0] out_value_r;
  logic [ORIGIN_W-1:0]     origin_r;
  logic                    last_r;
  logic                    ovf_out_r;

  logic [KEY_W-1:0]        key_a, key_b;
  logic signed [SUM_W-1:0] val_a, val_b, val_sel;
  logic [CNT_W:0]          ptr_a_inc, ptr_b_inc;
  logic                    adv_a, adv_b;

  // list memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= {row_index, col_index, entry_value};
    end
    if (cmd.fetch) begin
      rd_a_r <= mem_a[ptr_a_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= {row_index, col_index, entry_value};
    end
    if (cmd.fetch) begin
      rd_b_r <= mem_b[ptr_b_r[IDX_W-1:0]];
    end
  end

  assign key_a = rd_a_r[ENTRY_W-1:VAL_W];
  assign key_b = rd_b_r[ENTRY_W-1:VAL_W];
  assign val_a = {rd_a_r[VAL_W-1], rd_a_r[VAL_W-1:0]};
  assign val_b = {rd_b_r[VAL_W-1], rd_b_r[VAL_W-1:0]};

  assign ptr_a_inc = {1'b0, ptr_a_r} + (CNT_W+1)'(1);
  assign ptr_b_inc = {1'b0, ptr_b_r} + (CNT_W+1)'(1);

  assign adv_a = cmd.emit && (cmd.origin != ORIG_B);
  assign adv_b = cmd.emit && (cmd.origin != ORIG_A);

  always_comb begin
    unique case (cmd.origin)
      ORIG_A:  val_sel = val_a;
      ORIG_B:  val_sel = val_b;
      ORIG_AB: val_sel = val_a + val_b;
      default: val_sel = val_a;
    endcase
  end

  always_comb begin
    sts.a_full     = (cnt_a_r == CNT_W'(LIST_DEPTH));
    sts.b_full     = (cnt_b_r == CNT_W'(LIST_DEPTH));
    sts.both_empty = (cnt_a_r == '0) && (cnt_b_r == '0);
    sts.a_left     = (ptr_a_r < cnt_a_r);
    sts.b_left     = (ptr_b_r < cnt_b_r);
    sts.a_more     = (ptr_a_inc < {1'b0, cnt_a_r});
    sts.b_more     = (ptr_b_inc < {1'b0, cnt_b_r});
    sts.a_lt       = (key_a < key_b);
    sts.a_gt       = (key_a > key_b);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  // counts, pointers and the sticky dropped-load flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ptr_a_r <= '0;
      ptr_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.clr) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (cmd.wr_a) begin
          cnt_a_r <= cnt_a_r + CNT_W'(1);
        end
        if (cmd.wr_b) begin
          cnt_b_r <= cnt_b_r + CNT_W'(1);
        end
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.ptr_rst) begin
        ptr_a_r <= '0;
        ptr_b_r <= '0;
      end else begin
        if (adv_a) begin
          ptr_a_r <= ptr_a_inc[CNT_W-1:0];
        end
        if (adv_b) begin
          ptr_b_r <= ptr_b_inc[CNT_W-1:0];
        end
      end
    end
  end

  // result register; the merge waits in emit while a stalled consumer holds it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= (cmd.origin == ORIG_B) ? key_b[KEY_W-1:COL_W] : key_a[KEY_W-1:COL_W];
      out_col_r   <= (cmd.origin == ORIG_B) ? key_b[COL_W-1:0] : key_a[COL_W-1:0];
      out_value_r <= val_sel;
      origin_r    <= cmd.origin;
      last_r      <= cmd.last;
      ovf_out_r   <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign origin_code   = origin_r;
  assign last_entry    = last_r;
  assign overflow_seen = ovf_out_r;

endmodule

// ===== design/stma_chk.sv =====
// port-level checks for the sparse triplet merge block, bound to the top level
`include "sparse_triplet_merge_add_top_assert.svh"

module stma_chk import stma_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [OP_W-1:0]         in_op,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [ROW_W-1:0]        out_row,
  input logic [COL_W-1:0]        out_col,
  input logic signed [SUM_W-1:0] out_value,
  input logic [ORIGIN_W-1:0]     origin_code,
  input logic                    last_entry,
  input logic                    overflow_seen
);

  // a result waiting on the consumer keeps its payload
  `STMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({out_row, out_col, out_value, origin_code, last_entry,
    overflow_seen}), "result payload changed while stalled")

  // a pending result that is not the final one means the merge is still going
  `STMA_ASSERT_NOW(a_busy_mid_run, out_valid && !last_entry, !in_ready,
    "input taken during a merge")

  // a load transfer never produces a result
  `STMA_ASSERT_NEXT(a_load_silent,
    in_valid && in_ready && (in_op == OP_LOAD_A || in_op == OP_LOAD_B),
    !$rose(out_valid), "result raised by a load")

endmodule

bind sparse_triplet_merge_add_top stma_chk u_stma_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_op         (in_if.op),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_row       (out_if.out_row),
  .out_col       (out_if.out_col),
  .out_value     (out_if.out_value),
  .origin_code   (out_if.origin_code),
  .last_entry    (out_if.last_entry),
  .overflow_seen (out_if.overflow_seen)
);
